// ===== rtl/core/itrt_pkg.sv =====
// itrt_pkg: types, codes and the digit-to-character function for the radix text converter.
// No dependencies; imported by itrt_ctrl, itrt_dp and integer_to_radix_text.
`default_nettype none

package itrt_pkg;

  // Largest text the character store ever has to hold.
  localparam int TEXT_CAP = 64;

  localparam logic [1:0] MODE_SIGNED = 2'd0;
  localparam logic [1:0] MODE_HEX    = 2'd1;
  localparam logic [1:0] MODE_OCT    = 2'd2;
  localparam logic [1:0] MODE_BIN    = 2'd3;

  localparam logic [7:0] RADIX_MIN = 8'd2;
  localparam logic [7:0] RADIX_MAX = 8'd36;

  localparam logic [63:0] MOST_NEGATIVE = {1'b1, 63'd0};

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ALPHA = 8'h37;   // 'A' minus ten

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_RADIX = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV_INIT,
    S_STEP,
    S_SIGN,
    S_READ,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [63:0] value;
    logic [7:0]         radix;
  } in_word_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       is_last;
    status_t    status;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic put_zero;
    logic put_sign;
    logic rd_first;
    logic rd_next;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic mag_zero;
    logic pow2;
    logic neg;
    logic digit_done;
    logic digit_last;
    logic rd_last;
  } dp_status_t;

  function automatic logic [7:0] digit_glyph(input logic [5:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    return (d < 6'd10) ? (CHAR_ZERO + d8) : (CHAR_ALPHA + d8);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itrt_dp.sv =====
// itrt_dp: magnitude register, byte-serial divider, shift digit path and character store.
// Depends on itrt_pkg; driven by the commands of itrt_ctrl.
`default_nettype none

module itrt_dp #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                   clk,
  input  itrt_pkg::in_word_t     in_word,
  input  itrt_pkg::dp_cmd_t      cmd,
  output itrt_pkg::dp_status_t   status,
  output itrt_pkg::out_word_t    res_word
);
  import itrt_pkg::*;

  localparam int DEPTH = (MAX_DIGITS < TEXT_CAP) ? MAX_DIGITS + 1 : TEXT_CAP;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] LAST_N = CW'(MAX_DIGITS - 1);

  logic [63:0]   mag_r;
  logic [5:0]    base_r;
  logic [2:0]    shift_r;
  logic          pow2_r;
  logic          neg_r;
  status_t       err_r;
  logic [CW-1:0] n_r;
  logic [5:0]    rem_r;
  logic [2:0]    chunk_r;
  logic [AW-1:0] rd_ptr_r;
  logic [7:0]    rd_data_r;
  logic [7:0]    mem [DEPTH];

  // load decode
  logic          sgn_ld;
  logic          neg_ld;
  logic [63:0]   mag_ld;
  logic [5:0]    base_ld;
  logic [2:0]    shift_ld;
  logic          pow2_ld;
  status_t       err_ld;

  always_comb begin
    sgn_ld   = (in_word.mode == MODE_SIGNED);
    neg_ld   = sgn_ld && in_word.value[63];
    mag_ld   = neg_ld ? (~in_word.value + 64'd1) : in_word.value;
    if (sgn_ld && ((in_word.radix < RADIX_MIN) || (in_word.radix > RADIX_MAX))) begin
      err_ld = STAT_BAD_RADIX;
    end else if (sgn_ld && (in_word.value == MOST_NEGATIVE)) begin
      err_ld = STAT_OVERFLOW;
    end else begin
      err_ld = STAT_OK;
    end
    case (in_word.mode)
      MODE_HEX: begin
        base_ld = 6'd16; shift_ld = 3'd4; pow2_ld = 1'b1;
      end
      MODE_OCT: begin
        base_ld = 6'd8;  shift_ld = 3'd3; pow2_ld = 1'b1;
      end
      MODE_BIN: begin
        base_ld = 6'd2;  shift_ld = 3'd1; pow2_ld = 1'b1;
      end
      default: begin
        base_ld = in_word.radix[5:0];
        pow2_ld = 1'b1;
        case (in_word.radix)
          8'd2:    shift_ld = 3'd1;
          8'd4:    shift_ld = 3'd2;
          8'd8:    shift_ld = 3'd3;
          8'd16:   shift_ld = 3'd4;
          8'd32:   shift_ld = 3'd5;
          default: begin
            shift_ld = 3'd1;
            pow2_ld  = 1'b0;
          end
        endcase
      end
    endcase
  end

  // one digit step: a byte of long division, or a shift for power-of-two bases
  logic [2:0]  top;
  logic [7:0]  chunk_bits;
  logic [7:0]  q;
  logic [6:0]  r7;
  logic [5:0]  r;
  logic [5:0]  mask;
  logic [5:0]  digit;
  logic [63:0] mag_step;
  logic        digit_done;
  logic        digit_last;

  always_comb begin
    top = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (mag_r[i*8 +: 8] != 8'd0) top = 3'(i);
    end
    chunk_bits = mag_r[{chunk_r, 3'b000} +: 8];
    r = rem_r;
    for (int j = 7; j >= 0; j--) begin
      r7 = {r, chunk_bits[j]};
      if (r7 >= {1'b0, base_r}) begin
        r7   = r7 - {1'b0, base_r};
        q[j] = 1'b1;
      end else begin
        q[j] = 1'b0;
      end
      r = r7[5:0];
    end
    mask = 6'((7'd1 << shift_r) - 7'd1);
    if (pow2_r) begin
      digit      = mag_r[5:0] & mask;
      mag_step   = mag_r >> shift_r;
      digit_done = 1'b1;
    end else begin
      digit      = r;
      mag_step   = mag_r;
      mag_step[{chunk_r, 3'b000} +: 8] = q;
      digit_done = (chunk_r == 3'd0);
    end
    digit_last = (mag_step == 64'd0) || (n_r == LAST_N);
  end

  // character store ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  always_comb begin
    wr_en   = cmd.put_zero || cmd.put_sign || (cmd.step && digit_done);
    wr_addr = n_r[AW-1:0];
    if (cmd.put_zero) begin
      wr_data = CHAR_ZERO;
    end else if (cmd.put_sign) begin
      wr_data = CHAR_MINUS;
    end else begin
      wr_data = digit_glyph(digit);
    end
    rd_en   = cmd.rd_first || cmd.rd_next;
    rd_addr = cmd.rd_first ? AW'(n_r - CW'(1)) : (rd_ptr_r - AW'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r   <= mag_ld;
      base_r  <= base_ld;
      shift_r <= shift_ld;
      pow2_r  <= pow2_ld;
      neg_r   <= neg_ld;
      err_r   <= err_ld;
      n_r     <= '0;
    end
    if (cmd.start) begin
      rem_r   <= 6'd0;
      chunk_r <= top;
    end
    if (cmd.step) begin
      mag_r   <= mag_step;
      rem_r   <= r;
      chunk_r <= chunk_r - 3'd1;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
      n_r          <= n_r + CW'(1);
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_ptr_r  <= rd_addr;
    end
  end

  always_comb begin
    status.err        = (err_r != STAT_OK);
    status.mag_zero   = (mag_r == 64'd0);
    status.pow2       = pow2_r;
    status.neg        = neg_r;
    status.digit_done = digit_done;
    status.digit_last = digit_last;
    status.rd_last    = (rd_ptr_r == '0);
    if (err_r != STAT_OK) begin
      res_word.text_char = 8'd0;
      res_word.is_last   = 1'b1;
      res_word.status    = err_r;
    end else begin
      res_word.text_char = rd_data_r;
      res_word.is_last   = (rd_ptr_r == '0);
      res_word.status    = STAT_OK;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/itrt_ctrl.sv =====
// itrt_ctrl: sequencing state machine for the radix text converter.
// Depends on itrt_pkg; commands itrt_dp and reads its status.
`default_nettype none

module itrt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_free,
  input  itrt_pkg::dp_status_t status,
  output logic                 busy,
  output itrt_pkg::dp_cmd_t    cmd
);
  import itrt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (status.err) begin
          state_nxt = S_ERR;
        end else if (status.mag_zero) begin
          state_nxt = S_READ;
        end else if (status.pow2) begin
          state_nxt = S_STEP;
        end else begin
          state_nxt = S_DIV_INIT;
        end
      end
      S_DIV_INIT: state_nxt = S_STEP;
      S_STEP: begin
        if (status.digit_done) begin
          if (status.digit_last) begin
            state_nxt = status.neg ? S_SIGN : S_READ;
          end else if (!status.pow2) begin
            state_nxt = S_DIV_INIT;
          end
        end
      end
      S_SIGN: state_nxt = S_READ;
      S_READ: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free && status.rd_last) state_nxt = S_IDLE;
      end
      S_ERR: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = in_valid;
      end
      S_PREP: begin
        cmd.put_zero = !status.err && status.mag_zero;
      end
      S_DIV_INIT: cmd.start = 1'b1;
      S_STEP:     cmd.step = 1'b1;
      S_SIGN:     cmd.put_sign = 1'b1;
      S_READ:     cmd.rd_first = 1'b1;
      S_EMIT: begin
        cmd.out_load = out_free;
        cmd.rd_next  = out_free && !status.rd_last;
      end
      S_ERR:      cmd.out_load = out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/integer_to_radix_text.sv =====
// integer_to_radix_text: formats a 64-bit integer as ASCII text, one character per word.
// Sequence: set-up, then per digit a shift for power-of-two bases; otherwise a divider
// start and a step for each significant byte (1 to 8) left in the magnitude (the byte-serial
// divider); then a minus sign if negative, then one character per cycle while not stalled.
// Throughput: one number at a time; the next is taken once its last word is registered.
// Reset: state machine idle and output word empty; the character store needs no clearing.
`default_nettype none

module integer_to_radix_text #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  itrt_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output itrt_pkg::out_word_t out_word
);
  import itrt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  out_word_t  res_word;
  logic       busy;
  logic       out_free;

  // Output register: holds a word until taken, so the converter can move on.
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_word_t  out_word_r;

  // A free slot: empty, or its word leaves at this edge.
  assign out_free = !out_valid_r || !out_stall;

  itrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  itrt_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk      (clk),
    .in_word  (in_word),
    .cmd      (cmd),
    .status   (status),
    .res_word (res_word)
  );

  // Stall the input for the whole conversion and emission of a number.
  assign in_stall = busy;

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;          // drop once taken
    end else begin
      out_valid_nxt = out_valid_r;   // hold while stalled
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_word_r <= res_word;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for integer_to_radix_text, the 64-bit integer to ASCII text block.
// Depends on itrt_pkg for the word types and codes; a local predictor builds expected words.

module tb;
  import itrt_pkg::*;

  localparam int DIGIT_LIMIT  = 64;         // matches the block's default MAX_DIGITS
  localparam int CYCLE_LIMIT  = 1_000_000;  // generous ceiling on the whole run
  localparam int DRAIN_CYCLES = 40;         // settle time once nothing is outstanding
  localparam int HOLD_CYCLES  = 600;        // long receiver hold-off for the fill-up test

  localparam logic [7:0] ASCII_DIGIT0 = 8'h30;
  localparam logic [7:0] ASCII_UPPERA = 8'h41;
  localparam logic [7:0] ASCII_DASH   = 8'h2D;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // Characters still owed by the block, oldest first.
  out_word_t   expected_text[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Idle rates in percent, changed between test phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Long hold-off: the test asks, the stall process counts it down.
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;

  integer_to_radix_text dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Stop a hung run: report failure once the cycle ceiling is passed.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("integer_to_radix_text: mismatch");
      $finish;
    end
  end

  // Work out the text of one number and queue its characters, most significant first.
  function automatic void predict_text(input in_word_t w);
    logic [63:0] mag;
    logic [63:0] base;
    logic [63:0] dig;
    logic [7:0]  reversed[$];
    logic        negative;
    status_t     fault;
    out_word_t   r;

    mag      = w.value;
    negative = 1'b0;
    fault    = STAT_OK;
    case (w.mode)
      MODE_SIGNED: begin
        // Radix check takes priority over the unrepresentable value.
        if (w.radix < RADIX_MIN || w.radix > RADIX_MAX) begin
          fault = STAT_BAD_RADIX;
        end else if (w.value == MOST_NEGATIVE) begin
          fault = STAT_OVERFLOW;
        end else if (w.value[63]) begin
          negative = 1'b1;
          mag      = -mag;
        end
        base = {56'd0, w.radix};
      end
      MODE_HEX: base = 64'd16;
      MODE_OCT: base = 64'd8;
      default:  base = 64'd2;
    endcase

    if (fault != STAT_OK) begin
      r.text_char = 8'd0;
      r.is_last   = 1'b1;
      r.status    = fault;
      expected_text.push_back(r);
      return;
    end

    if (mag == 64'd0) begin
      reversed.push_back(ASCII_DIGIT0);
    end else begin
      // Keep only the least significant digits if the limit bites.
      while (mag != 64'd0 && reversed.size() < DIGIT_LIMIT) begin
        dig = mag % base;
        reversed.push_back((dig < 10) ? ASCII_DIGIT0 + dig[7:0]
                                      : ASCII_UPPERA + dig[7:0] - 8'd10);
        mag = mag / base;
      end
    end
    if (negative && reversed.size() < DIGIT_LIMIT) begin
      reversed.push_back(ASCII_DASH);
    end

    for (int k = reversed.size() - 1; k >= 0; k--) begin
      r.text_char = reversed[k];
      r.is_last   = (k == 0);
      r.status    = STAT_OK;
      expected_text.push_back(r);
    end
  endfunction

  // Receiver side: hold off for a requested stretch, otherwise stall at random.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // Compare every accepted word with the oldest expected character.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, out_word);
        mismatches++;
      end else begin
        want = expected_text.pop_front();
        if (out_word.text_char !== want.text_char) begin
          $display("%0t: text_char expected %h actual %h",
                   $time, want.text_char, out_word.text_char);
          mismatches++;
        end
        if (out_word.is_last !== want.is_last) begin
          $display("%0t: is_last expected %b actual %b", $time, want.is_last, out_word.is_last);
          mismatches++;
        end
        if (out_word.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_word.status);
          mismatches++;
        end
      end
    end
  end

  // Offer one number, idling first at the current rate, and hold it until taken.
  // Valid is left high on return so back-to-back numbers leave no gap.
  task automatic send_number(input logic [1:0] mode, input logic [63:0] value,
                             input logic [7:0] radix);
    in_word_t w;
    w.mode  = mode;
    w.value = value;
    w.radix = radix;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    predict_text(w);
  endtask

  // Drop valid, wait for every owed character, then let the block settle.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random number: mostly short magnitudes, both signs, mostly valid radices.
  task automatic send_random_number();
    logic [63:0] raw;
    logic [1:0]  mode;
    logic [7:0]  radix;
    raw  = {$urandom, $urandom};
    if ($urandom_range(99) < 70) raw = raw >> $urandom_range(63);
    mode = 2'($urandom_range(3));
    if (mode == MODE_SIGNED && $urandom_range(1)) raw = -raw;
    if ($urandom_range(49) == 0) raw = MOST_NEGATIVE;
    radix = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(36, 2));
    send_number(mode, raw, radix);
  endtask

  // Signed mode corners: zero, one, extremes, smallest and largest radix, bad radices,
  // the unrepresentable most negative value, and radix priority over it.
  task automatic test_signed_edges();
    send_number(MODE_SIGNED, 64'd0, 8'd10);
    send_number(MODE_SIGNED, 64'd1, 8'd10);
    send_number(MODE_SIGNED, -64'd1, 8'd10);
    send_number(MODE_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 8'd2);
    send_number(MODE_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 8'd36);
    send_number(MODE_SIGNED, 64'h8000_0000_0000_0001, 8'd2);   // sign plus 63 digits
    send_number(MODE_SIGNED, 64'h8000_0000_0000_0001, 8'd3);   // slowest divide
    send_number(MODE_SIGNED, MOST_NEGATIVE, 8'd10);
    send_number(MODE_SIGNED, MOST_NEGATIVE, 8'd255);
    send_number(MODE_SIGNED, 64'd123, 8'd0);
    send_number(MODE_SIGNED, 64'd123, 8'd1);
    send_number(MODE_SIGNED, 64'd123, 8'd37);
    send_number(MODE_SIGNED, 64'd123, 8'd255);
    send_number(MODE_SIGNED, -64'd12345, 8'd16);
    send_number(MODE_SIGNED, 64'd35, 8'd36);
    wait_drain();
  endtask

  // Unsigned modes read all 64 bits and ignore whatever sits in the radix field.
  task automatic test_unsigned_modes();
    send_number(MODE_HEX, '1, 8'd0);
    send_number(MODE_OCT, '1, 8'd37);
    send_number(MODE_BIN, '1, 8'd255);
    send_number(MODE_HEX, 64'd0, 8'd10);
    send_number(MODE_OCT, 64'd0, 8'd1);
    send_number(MODE_BIN, 64'd0, 8'd200);
    send_number(MODE_HEX, MOST_NEGATIVE, 8'd10);
    send_number(MODE_OCT, 64'h0123_4567_89AB_CDEF, 8'd2);
    send_number(MODE_BIN, 64'd1, 8'd36);
    wait_drain();
  endtask

  task automatic test_random(input int count, input int unsigned send_pct,
                             input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_random_number();
    wait_drain();
  endtask

  // Hold the receiver off for a long stretch while numbers keep coming, so the
  // block fills and stalls its input; then release and let it drain.
  task automatic test_long_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    repeat (12) send_random_number();
    wait_drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_signed_edges();
    test_unsigned_modes();
    test_random(80, 19, 83);
    test_random(80, 83, 19);
    test_long_hold();
    test_random(80, 0, 0);

    if (mismatches == 0) begin
      $display("integer_to_radix_text: match");
    end else begin
      $display("integer_to_radix_text: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/itrt_pkg.sv
rtl/core/itrt_dp.sv
rtl/core/itrt_ctrl.sv
rtl/core/integer_to_radix_text.sv
bench/tb.sv
